// ----- design/gws_pkg.sv -----
`default_nettype none

package gws_pkg;

	localparam int CFG_W    = 9;
	localparam int CH_W     = 8;
	localparam int TOTAL_W  = 19;
	localparam int WIN_LEN  = 7;
	localparam int HIST_LEN = 3;
	localparam int HITS_W   = 3;

	typedef logic [CH_W-1:0] char_t;

	// Element 0 is the newest tap of the row; element j lies j cells further back.
	typedef char_t [WIN_LEN-1:0] win_row_t;

	typedef struct packed {
		win_row_t row1;
		win_row_t row2;
		win_row_t row3;
	} win_t;

	// Element 0 is the previous character of the stream.
	typedef char_t [HIST_LEN-1:0] hist_t;

	typedef struct packed {
		logic horiz;
		logic vert;
		logic diag;
		logic anti;
	} chk_t;

endpackage

`default_nettype wire

// ----- design/gws_in_if.sv -----
`default_nettype none

interface gws_in_if;
	import gws_pkg::*;

	logic  valid;
	logic  ready;
	char_t ch;
	logic  last_cell;

	modport src (output valid, ch, last_cell, input ready);
	modport sink (input valid, ch, last_cell, output ready);
endinterface

`default_nettype wire

// ----- design/gws_out_if.sv -----
`default_nettype none

interface gws_out_if;
	import gws_pkg::*;

	logic               valid;
	logic               ready;
	logic [TOTAL_W-1:0] match_total;

	modport src (output valid, match_total, input ready);
	modport sink (input valid, match_total, output ready);
endinterface

`default_nettype wire

// ----- design/gws_ram.sv -----
`default_nettype none

module gws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

`default_nettype wire

// ----- design/gws_lines.sv -----
`default_nettype none

module gws_lines #(
	parameter int MAX_WIDTH = 256,
	parameter int COL_W     = $clog2(MAX_WIDTH)
) (
	input  logic             clk,
	input  logic             acc,
	input  gws_pkg::char_t   ch,
	input  logic [COL_W-1:0] col,
	input  logic [COL_W-1:0] col_ahead,
	input  logic             adv,
	input  logic [COL_W-1:0] col_s1,
	output gws_pkg::win_t    win
);
	import gws_pkg::*;

	char_t                 rd1;
	char_t                 rd2;
	char_t                 rd3;
	char_t [WIN_LEN-2:0]   h1_q;
	char_t [WIN_LEN-2:0]   h2_q;
	char_t [WIN_LEN-2:0]   h3_q;

	// row1 delays the stream by width-3, rows 2 and 3 by a further width each
	gws_ram #(.WIDTH(CH_W), .DEPTH(MAX_WIDTH)) u_row1 (
		.clk   (clk),
		.we    (acc),
		.waddr (col),
		.wdata (ch),
		.re    (acc),
		.raddr (col_ahead),
		.rdata (rd1)
	);

	gws_ram #(.WIDTH(CH_W), .DEPTH(MAX_WIDTH)) u_row2 (
		.clk   (clk),
		.we    (adv),
		.waddr (col_s1),
		.wdata (rd1),
		.re    (acc),
		.raddr (col),
		.rdata (rd2)
	);

	gws_ram #(.WIDTH(CH_W), .DEPTH(MAX_WIDTH)) u_row3 (
		.clk   (clk),
		.we    (adv),
		.waddr (col_s1),
		.wdata (rd2),
		.re    (acc),
		.raddr (col),
		.rdata (rd3)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			h1_q <= {h1_q[WIN_LEN-3:0], rd1};
			h2_q <= {h2_q[WIN_LEN-3:0], rd2};
			h3_q <= {h3_q[WIN_LEN-3:0], rd3};
		end
	end

	assign win.row1 = {h1_q, rd1};
	assign win.row2 = {h2_q, rd2};
	assign win.row3 = {h3_q, rd3};
endmodule

`default_nettype wire

// ----- design/gws_match.sv -----
`default_nettype none

module gws_match (
	input  gws_pkg::char_t                ch,
	input  gws_pkg::hist_t                recent,
	input  gws_pkg::win_t                 win,
	input  gws_pkg::chk_t                 chk,
	output logic [gws_pkg::HITS_W-1:0]    hits
);
	import gws_pkg::*;

	localparam char_t CH_X = 8'h58;
	localparam char_t CH_M = 8'h4D;
	localparam char_t CH_A = 8'h41;
	localparam char_t CH_S = 8'h53;

	// window taps: row k holds columns c+k down to c-k at these places
	localparam int TAP_R1_AHEAD = 2;
	localparam int TAP_R2_AHEAD = 1;
	localparam int TAP_R3_AHEAD = 0;
	localparam int TAP_SAME     = 3;
	localparam int TAP_R1_BACK  = 4;
	localparam int TAP_R2_BACK  = 5;
	localparam int TAP_R3_BACK  = 6;

	function automatic logic is_word(char_t a, char_t b, char_t c, char_t d);
		return (a == CH_X && b == CH_M && c == CH_A && d == CH_S) ||
		       (a == CH_S && b == CH_A && c == CH_M && d == CH_X);
	endfunction

	logic h_hit;
	logic v_hit;
	logic d_hit;
	logic a_hit;

	assign h_hit = chk.horiz & is_word(recent[2], recent[1], recent[0], ch);
	assign v_hit = chk.vert & is_word(win.row3[TAP_SAME], win.row2[TAP_SAME],
	                                  win.row1[TAP_SAME], ch);
	assign d_hit = chk.diag & is_word(win.row3[TAP_R3_BACK], win.row2[TAP_R2_BACK],
	                                  win.row1[TAP_R1_BACK], ch);
	assign a_hit = chk.anti & is_word(win.row3[TAP_R3_AHEAD], win.row2[TAP_R2_AHEAD],
	                                  win.row1[TAP_R1_AHEAD], ch);

	assign hits = HITS_W'(h_hit) + HITS_W'(v_hit) + HITS_W'(d_hit) + HITS_W'(a_hit);
endmodule

`default_nettype wire

// ----- design/grid_word_search_counter_top.sv -----
`default_nettype none

// Streams a character grid in raster order, one byte per beat on grid_in, and
// counts every line of four cells reading XMAS or SAMX along rows, columns and
// both diagonals. The row width comes from cfg_wdata (clamped to 4..MAX_WIDTH);
// writing it restarts the grid. One total leaves on result for each beat marked
// last_cell, via the input register and then the output register, saturating at
// 262144. Throughput is one character per clock unless grid_in stalls; the
// three previous rows live in three single-port-read line buffers of MAX_WIDTH
// bytes, each read once per beat, feeding seven-byte tap windows. grid_in
// stalls only while a finished total waits on result and the next last_cell
// beat is ready to leave the input register. No clearing pass after reset; a
// line is scored only once all of its cells belong to the current grid.
module grid_word_search_counter_top #(
	parameter int MAX_WIDTH = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [gws_pkg::CFG_W-1:0]   cfg_wdata,
	gws_in_if.sink                      grid_in,
	gws_out_if.src                      result
);
	import gws_pkg::*;

	localparam int                 COL_W     = $clog2(MAX_WIDTH);
	localparam int                 WID_W     = $clog2(MAX_WIDTH + 1);
	localparam int                 MIN_WIDTH = 4;
	localparam int                 LOOK      = 3;
	localparam logic [1:0]         ROWS_FULL = 2'd3;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(262144);

	logic [WID_W-1:0]   w_q;
	logic [WID_W-1:0]   w_cfg;
	logic [31:0]        cfg_ext;
	logic [COL_W-1:0]   col_q;
	logic [1:0]         rows_q;
	logic [COL_W:0]     col_inc;
	logic [COL_W:0]     col_look;
	logic               col_end;
	logic               ahead_wrap;
	logic [COL_W-1:0]   col_ahead;
	logic               acc;
	logic               adv;
	chk_t               chk_next;

	logic               valid_s1;
	logic               last_s1;
	char_t              ch_s1;
	logic [COL_W-1:0]   col_s1;
	chk_t               chk_s1;

	hist_t              recent_q;
	win_t               win;
	logic [HITS_W-1:0]  hits;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] total_sat;
	logic [TOTAL_W-1:0] total_q;
	logic               out_valid_q;
	logic [TOTAL_W-1:0] out_total_q;

	assign cfg_ext = 32'(cfg_wdata);

	always_comb begin
		priority if (cfg_ext < 32'(MIN_WIDTH)) begin
			w_cfg = WID_W'(MIN_WIDTH);
		end else if (cfg_ext > 32'(MAX_WIDTH)) begin
			w_cfg = WID_W'(MAX_WIDTH);
		end else begin
			w_cfg = WID_W'(cfg_ext);
		end
	end

	assign acc           = grid_in.valid & grid_in.ready;
	assign adv           = valid_s1 & (~last_s1 | ~out_valid_q | result.ready);
	assign grid_in.ready = ~valid_s1 | adv;

	assign col_inc    = (COL_W+1)'(col_q) + (COL_W+1)'(1);
	assign col_end    = col_inc == (COL_W+1)'(w_q);
	assign col_look   = (COL_W+1)'(col_q) + (COL_W+1)'(LOOK);
	assign ahead_wrap = col_look >= (COL_W+1)'(w_q);
	assign col_ahead  = ahead_wrap ? COL_W'(col_look - (COL_W+1)'(w_q)) : COL_W'(col_look);

	assign chk_next.horiz = col_q >= COL_W'(LOOK);
	assign chk_next.vert  = rows_q == ROWS_FULL;
	assign chk_next.diag  = (rows_q == ROWS_FULL) & (col_q >= COL_W'(LOOK));
	assign chk_next.anti  = (rows_q == ROWS_FULL) & ~ahead_wrap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= WID_W'(MAX_WIDTH);
			col_q  <= '0;
			rows_q <= '0;
		end else if (cfg_we) begin
			w_q    <= w_cfg;
			col_q  <= '0;
			rows_q <= '0;
		end else if (acc) begin
			priority if (grid_in.last_cell) begin
				col_q  <= '0;
				rows_q <= '0;
			end else if (col_end) begin
				col_q <= '0;
				if (rows_q != ROWS_FULL) begin
					rows_q <= rows_q + 2'd1;
				end
			end else begin
				col_q <= COL_W'(col_inc);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
			last_s1  <= grid_in.last_cell;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ch_s1  <= grid_in.ch;
			col_s1 <= col_q;
			chk_s1 <= chk_next;
		end
		if (adv) begin
			recent_q <= {recent_q[HIST_LEN-2:0], ch_s1};
		end
	end

	gws_lines #(.MAX_WIDTH(MAX_WIDTH), .COL_W(COL_W)) u_lines (
		.clk       (clk),
		.acc       (acc),
		.ch        (grid_in.ch),
		.col       (col_q),
		.col_ahead (col_ahead),
		.adv       (adv),
		.col_s1    (col_s1),
		.win       (win)
	);

	gws_match u_match (
		.ch     (ch_s1),
		.recent (recent_q),
		.win    (win),
		.chk    (chk_s1),
		.hits   (hits)
	);

	assign sum       = (TOTAL_W+1)'(total_q) + (TOTAL_W+1)'(hits);
	assign total_sat = (sum > (TOTAL_W+1)'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cfg_we) begin
			total_q <= '0;
		end else if (adv) begin
			total_q <= last_s1 ? '0 : total_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			out_total_q <= total_sat;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.match_total = out_total_q;

`ifndef NO_ASSERTIONS
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(COL_W+1)'(col_q) < (COL_W+1)'(w_q))
		else $error("column position beyond row width");

	a_total_cap: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TOTAL_MAX)
		else $error("running total above saturation limit");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(adv && last_s1))
		else $error("result raised without a last beat leaving the input stage");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!grid_in.ready |-> (valid_s1 && last_s1 && result.valid && !result.ready))
		else $error("input held off without a blocked total");

	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (col_q == '0 && rows_q == '0 && total_q == '0))
		else $error("width write did not restart the grid");
`endif
endmodule

`default_nettype wire

// ----- dv/tb_grid_word_search_counter_top.sv -----
module tb_grid_word_search_counter_top;
	import gws_pkg::*;

	localparam int unsigned MAX_W        = 256;
	localparam int unsigned TOTAL_CAP    = 262144;
	localparam int unsigned GAP_MAX      = 17;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned STALL_LIMIT  = 4000;
	localparam int unsigned ITEM_TARGET  = 1600;

	localparam char_t LET_X = 8'h58;
	localparam char_t LET_M = 8'h4D;
	localparam char_t LET_A = 8'h41;
	localparam char_t LET_S = 8'h53;

	typedef enum int {FILL_RANDOM, FILL_WAVE} fill_t;

	class total_board;
		char_t              row_mem [3*MAX_W];
		logic [23:0]        recent;
		logic [23:0]        evicted;
		int unsigned        col;
		int unsigned        full_rows;
		int unsigned        slot;
		int unsigned        width_reg;
		int unsigned        tally;
		logic [TOTAL_W-1:0] totals_due [$];
		int                 mismatches;

		function new();
			foreach (row_mem[i]) row_mem[i] = '0;
			width_reg  = MAX_W;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			recent    = '0;
			evicted   = '0;
			col       = 0;
			full_rows = 0;
			slot      = 0;
			tally     = 0;
		endfunction

		function void load_width(logic [CFG_W-1:0] value);
			width_reg = value;
			restart();
		endfunction

		function int unsigned eff_width();
			if (width_reg < 4) return 4;
			if (width_reg > MAX_W) return MAX_W;
			return width_reg;
		endfunction

		function char_t stored(int unsigned back, int unsigned c);
			if (c >= MAX_W) return '0;
			return row_mem[((slot + 3 - back) % 3) * MAX_W + c];
		endfunction

		function int unsigned word4(char_t a, char_t b, char_t c, char_t d);
			if (a == LET_X && b == LET_M && c == LET_A && d == LET_S) return 1;
			if (a == LET_S && b == LET_A && c == LET_M && d == LET_X) return 1;
			return 0;
		endfunction

		function void note_cell(char_t ch, logic last);
			int unsigned w;
			int unsigned c;
			int unsigned hits;
			int unsigned idx;
			w    = eff_width();
			c    = col;
			hits = 0;
			if (c >= w) c = w - 1;
			if (c >= 3) hits += word4(recent[23:16], recent[15:8], recent[7:0], ch);
			if (full_rows >= 3) begin
				hits += word4(stored(3, c), stored(2, c), stored(1, c), ch);
				if (c >= 3)
					hits += word4(evicted[23:16], stored(2, c - 2), stored(1, c - 1), ch);
				if (c + 3 < w)
					hits += word4(stored(3, c + 3), stored(2, c + 2), stored(1, c + 1), ch);
			end
			tally += hits;
			if (tally > TOTAL_CAP) tally = TOTAL_CAP;
			idx          = slot * MAX_W + c;
			evicted      = {evicted[15:0], row_mem[idx]};
			row_mem[idx] = ch;
			recent       = {recent[15:0], ch};
			c++;
			if (c >= w) begin
				c = 0;
				if (full_rows < 3) full_rows++;
				slot    = (slot + 1) % 3;
				recent  = '0;
				evicted = '0;
			end
			col = c;
			if (last) begin
				totals_due = {totals_due, TOTAL_W'(tally)};
				restart();
			end
		endfunction

		function void check_total(logic [TOTAL_W-1:0] seen);
			logic [TOTAL_W-1:0] want;
			if (totals_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected total %0d", seen);
				return;
			end
			want = totals_due.pop_front();
			if (seen !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("total mismatch: expected %0d, got %0d", want, seen);
			end
		endfunction

		function int pending();
			return totals_due.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	gws_in_if  cell_bus ();
	gws_out_if result_bus ();

	total_board  sb;
	bit          idle_on    = 1'b0;
	bit          hold_req   = 1'b0;
	int unsigned beats_sent = 0;

	grid_word_search_counter_top #(
		.MAX_WIDTH(MAX_W)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.grid_in  (cell_bus),
		.result   (result_bus)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic char_t wave_at(int unsigned k);
		case (k % 6)
			0: return LET_X;
			1: return LET_M;
			2: return LET_A;
			3: return LET_S;
			4: return LET_A;
			default: return LET_M;
		endcase
	endfunction

	function automatic char_t word_letter();
		case ($urandom_range(0, 3))
			0: return LET_X;
			1: return LET_M;
			2: return LET_A;
			default: return LET_S;
		endcase
	endfunction

	function automatic char_t pick_char(fill_t fill, int unsigned r, int unsigned c,
			int unsigned shift, bit noisy);
		if (fill == FILL_WAVE && !(noisy && $urandom_range(0, 15) == 0))
			return wave_at(c + r * shift);
		if ($urandom_range(0, 4) == 0) return char_t'($urandom_range(0, 255));
		return word_letter();
	endfunction

	task automatic send_cell(char_t ch, logic last);
		cell_bus.valid     <= 1'b1;
		cell_bus.ch        <= ch;
		cell_bus.last_cell <= last;
		@(posedge clk);
		while (!cell_bus.ready) @(posedge clk);
		sb.note_cell(ch, last);
		beats_sent++;
	endtask

	task automatic take_gap();
		if (idle_on && $urandom_range(0, 11) == 0) begin
			cell_bus.valid <= 1'b0;
			repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
		end
	endtask

	task automatic send_grid(int unsigned n, fill_t fill, int unsigned shift, bit noisy,
			bit closes);
		int unsigned w;
		w = sb.eff_width();
		for (int unsigned k = 0; k < n; k++) begin
			send_cell(pick_char(fill, k / w, k % w, shift, noisy), closes && (k == n - 1));
			take_gap();
		end
	endtask

	// drop valid, wait out every pending total, then let in-flight beats drain
	task automatic settle();
		cell_bus.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_width(logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.load_width(value);
	endtask

	initial begin
		int unsigned burst_left;
		burst_left       = 0;
		result_bus.ready = 1'b0;
		forever begin
			if (hold_req) begin
				result_bus.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (burst_left != 0) begin
					result_bus.ready <= 1'b0;
					burst_left--;
				end else if (idle_on && $urandom_range(0, 9) == 0) begin
					result_bus.ready <= 1'b0;
					burst_left = $urandom_range(0, GAP_MAX - 1);
				end else begin
					result_bus.ready <= 1'b1;
				end
				@(posedge clk);
				if (result_bus.valid && result_bus.ready)
					sb.check_total(result_bus.match_total);
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((cell_bus.valid && cell_bus.ready) || (result_bus.valid && result_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		char_t       plate [16];
		char_t       tail [6];
		int unsigned pick;
		int unsigned wcode;
		int unsigned w;
		int unsigned grids;
		int unsigned rows;
		int unsigned n;
		sb                 = new();
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		cell_bus.valid     = 1'b0;
		cell_bus.ch        = '0;
		cell_bus.last_cell = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// lone cell at the reset width
		send_cell(8'hFF, 1'b1);
		settle();
		write_width(CFG_W'(4));
		// vertical, diagonal and anti-diagonal hits in one 4x4 grid
		plate = '{LET_X, 8'h00, 8'hFF, LET_X,
		          LET_M, LET_M, LET_M, 8'hFF,
		          LET_A, LET_A, LET_A, LET_A,
		          LET_S, 8'h00, 8'hFF, LET_S};
		foreach (plate[k]) send_cell(plate[k], k == 15);
		// horizontal hit, grid closed mid-row
		tail = '{LET_S, LET_A, LET_M, LET_X, LET_S, LET_A};
		foreach (tail[k]) send_cell(tail[k], k == 5);
		settle();
		write_width('1);
		send_cell(LET_X, 1'b1);
		settle();
		write_width('0);
		send_cell(LET_S, 1'b1);

		while (beats_sent < ITEM_TARGET) begin
			settle();
			pick = $urandom_range(0, 15);
			if (pick < 12)
				wcode = $urandom_range(4, 12);
			else if (pick == 12)
				wcode = $urandom_range(0, 3);
			else if (pick < 15)
				wcode = $urandom_range(13, 64);
			else
				wcode = $urandom_range(256, 511);
			write_width(CFG_W'(wcode));
			idle_on = ($urandom_range(0, 3) != 0);
			w       = sb.eff_width();
			grids   = (w > 64) ? 1 : $urandom_range(1, 4);
			for (int unsigned g = 0; g < grids; g++) begin
				if (w <= 16)
					rows = $urandom_range(3, 7);
				else if (w <= 64)
					rows = $urandom_range(1, 4);
				else
					rows = ($urandom_range(0, 7) == 0) ? 4 : $urandom_range(0, 1);
				n = rows * w + (($urandom_range(0, 2) == 0) ? $urandom_range(1, w - 1) : 0);
				if ($urandom_range(0, 9) == 0) n = $urandom_range(1, 3);
				if (n == 0) n = 1;
				// leave the last grid open now and then so the width write cuts it off
				send_grid(n, ($urandom_range(0, 1) != 0) ? FILL_WAVE : FILL_RANDOM,
					$urandom_range(0, 5), 1'b1,
					!(g == grids - 1 && $urandom_range(0, 5) == 0));
			end
		end

		// hold the result side while short grids keep coming
		settle();
		write_width(CFG_W'($urandom_range(4, 8)));
		idle_on  = 1'b1;
		hold_req = 1'b1;
		for (int unsigned i = 0; i < 60; i++)
			send_grid($urandom_range(1, 5), FILL_WAVE, $urandom_range(0, 5), 1'b1, 1'b1);

		settle();
		idle_on = 1'b0;
		write_width(CFG_W'(5));
		for (int unsigned i = 0; i < 3; i++)
			send_grid($urandom_range(8, 30), FILL_RANDOM, 0, 1'b1, 1'b1);

		cell_bus.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (2 * DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
